FILE: rtl/plq_pkg.sv
// ----------------------------------------------------------------------------
// plq_pkg: shared types and constants of the partitioned load queue
// Holds the operation codes, the decoded request layout and the fixed sizes
// that the front end, the request queue and the execution back end share.
// ----------------------------------------------------------------------------
`default_nettype none

package plq_pkg;

   // fixed bank count and the width of a bank select
   localparam int NUM_BANKS = 4;
   localparam int BANK_W    = 2;

   // entries in the queue between front end and back end
   localparam int QUEUE_DEPTH = 4;

   // counter sizes and the scale-down applied when a counter saturates
   localparam int COUNT_W       = 16;
   localparam int COUNT_SHIFT   = 6;
   localparam int PARAM_W       = 8;
   localparam int STATS_INDEX_W = 11;
   localparam int STATS_SCALE_W = 3;   // write-back index is slot times 8
   localparam int WORD_W        = 64;

   // operation codes
   typedef enum logic [1:0] {
      FUNC_CHECK = 2'd0,
      FUNC_SAVE  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_INIT  = 2'd3
   } func_type;

   // decoded request as it travels through the queue (hash kept apart)
   typedef struct packed {
      func_type                func;
      logic [BANK_W-1:0]       bank;
      logic [WORD_W-1:0]       load_pc;
      logic [PARAM_W-1:0]      param_index;
      logic [COUNT_W-1:0]      spec_count;
      logic [COUNT_W-1:0]      miss_count;
      logic [WORD_W-1:0]       mask_low;
      logic [WORD_W-1:0]       mask_high;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

endpackage

`default_nettype wire

FILE: rtl/plq_front.sv
// ----------------------------------------------------------------------------
// plq_front: request intake and classification
// Registers an incoming request, decodes its operation and extracts the
// address hash, then hands the decoded request to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module plq_front
   import plq_pkg::*;
#(
   parameter int HASH_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // raw request fields
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [1:0]           in_func,
   input  wire logic [BANK_W-1:0]    in_bank,
   input  wire logic [WORD_W-1:0]    in_load_pc,
   input  wire logic [WORD_W-1:0]    in_mem_address,
   input  wire logic [PARAM_W-1:0]   in_param_index,
   input  wire logic [COUNT_W-1:0]   in_spec_count,
   input  wire logic [COUNT_W-1:0]   in_miss_count,
   input  wire logic [WORD_W-1:0]    in_mask_low,
   input  wire logic [WORD_W-1:0]    in_mask_high,
   // decoded request toward the queue
   output logic                      push,
   input  wire logic                 queue_full,
   output cmd_type                   cmd,
   output logic [HASH_BITS-1:0]      hash
);

   logic                  valid_ff, valid_in;
   cmd_type               cmd_ff, cmd_in;
   logic [HASH_BITS-1:0]  hash_ff, hash_in;
   logic                  accept;

   // hand over when the queue has room; take a new request when the slot frees
   assign push     = valid_ff && !queue_full;
   assign in_ready = !valid_ff || push;
   assign accept   = in_valid && in_ready;

   // decode the request: hash is address bits HASH_BITS+1:2
   always_comb begin
      cmd_in             = cmd_ff;
      hash_in            = hash_ff;
      if (accept) begin
         cmd_in.func        = func_type'(in_func);
         cmd_in.bank        = in_bank;
         cmd_in.load_pc     = in_load_pc;
         cmd_in.param_index = in_param_index;
         cmd_in.spec_count  = in_spec_count;
         cmd_in.miss_count  = in_miss_count;
         cmd_in.mask_low    = in_mask_low;
         cmd_in.mask_high   = in_mask_high;
         hash_in            = in_mem_address[HASH_BITS+1:2];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      hash_ff <= hash_in;
   end

   assign cmd  = cmd_ff;
   assign hash = hash_ff;

endmodule

`default_nettype wire

FILE: rtl/plq_queue.sv
// ----------------------------------------------------------------------------
// plq_queue: short request queue between front end and back end
// A small first-in first-out buffer of decoded requests so that intake and
// execution stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module plq_queue
   import plq_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [WIDTH-1:0]  push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   not_empty,
   output logic [WIDTH-1:0]       pop_data
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed request
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill level never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("request queue over depth");

   // the back end never drains an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("request queue popped while empty");

endmodule

`default_nettype wire

FILE: rtl/plq_exec.sv
// ----------------------------------------------------------------------------
// plq_exec: bank state and execution back end
// Holds four banks of hashed load history, their counters, masks and first pc;
// executes one request per cycle if responses drain and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module plq_exec
   import plq_pkg::*;
#(
   parameter int BANK_DEPTH = 8,
   parameter int HASH_BITS  = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request from the queue
   input  wire logic                       cmd_valid,
   output logic                            pop,
   input  wire cmd_type                    cmd,
   input  wire logic [HASH_BITS-1:0]       hash,
   // registered response
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rollback,
   output logic [WORD_W-1:0]               rollback_mask_low,
   output logic [WORD_W-1:0]               rollback_mask_high,
   output logic [WORD_W-1:0]               rollback_pc,
   output logic                            stats_write,
   output logic [STATS_INDEX_W-1:0]        stats_index,
   output logic [COUNT_W-1:0]              stats_spec_count,
   output logic [COUNT_W-1:0]              stats_miss_count
);

   // bank state
   logic [HASH_BITS-1:0]  hist_ff   [NUM_BANKS][BANK_DEPTH];
   logic [BANK_DEPTH-1:0] valid_ff  [NUM_BANKS];
   logic [COUNT_W-1:0]    spec_ff   [NUM_BANKS];
   logic [COUNT_W-1:0]    miss_ff   [NUM_BANKS];
   logic [PARAM_W-1:0]    param_ff  [NUM_BANKS];
   logic [WORD_W-1:0]     mlow_ff   [NUM_BANKS];
   logic [WORD_W-1:0]     mhigh_ff  [NUM_BANKS];
   logic [WORD_W-1:0]     fpc_ff    [NUM_BANKS];
   logic                  missed_ff [NUM_BANKS];

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rollback_ff;
   logic [WORD_W-1:0]          mlow_out_ff, mhigh_out_ff, pc_out_ff;
   logic                       stats_write_ff;
   logic [STATS_INDEX_W-1:0]   stats_index_ff;
   logic [COUNT_W-1:0]         spec_out_ff, miss_out_ff;

   logic [BANK_W-1:0]     b;
   logic [BANK_DEPTH-1:0] match;
   logic                  hit;
   logic [BANK_DEPTH-1:0] valid_shift;
   logic [COUNT_W-1:0]    spec_inc, miss_inc, spec_new, miss_new;
   logic                  is_check, is_clear;

   // take a request when the response register is free or being drained
   assign pop = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign b   = cmd.bank;
   assign is_check = (cmd.func == FUNC_CHECK);
   assign is_clear = (cmd.func == FUNC_CLEAR);

   // compare the hash against every entry of the selected bank
   always_comb begin
      for (int i = 0; i < BANK_DEPTH; i++) begin
         match[i] = valid_ff[b][i] && (hist_ff[b][i] == hash);
      end
   end
   assign hit = |match;

   // newest entry enters at index 0, oldest drops out
   assign valid_shift = (valid_ff[b] << 1) | BANK_DEPTH'(1);

   // on clear bump spec, and miss after a hit; scale down once spec hits bit 15
   always_comb begin
      spec_inc = spec_ff[b] + 1'b1;
      miss_inc = missed_ff[b] ? miss_ff[b] + 1'b1 : miss_ff[b];
      spec_new = spec_inc;
      miss_new = miss_inc;
      if (spec_inc[COUNT_W-1]) begin
         spec_new = spec_inc >> COUNT_SHIFT;
         miss_new = miss_inc >> COUNT_SHIFT;
      end
   end

   // update control state of the selected bank
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_BANKS; k++) begin
            valid_ff[k]  <= '0;
            spec_ff[k]   <= '0;
            miss_ff[k]   <= '0;
            param_ff[k]  <= '0;
            mlow_ff[k]   <= '0;
            mhigh_ff[k]  <= '0;
            fpc_ff[k]    <= '0;
            missed_ff[k] <= 1'b0;
         end
      end else if (pop) begin
         case (cmd.func)
            FUNC_SAVE: begin
               valid_ff[b] <= valid_shift;
               if (fpc_ff[b] == '0) begin
                  fpc_ff[b] <= cmd.load_pc;
               end
            end
            FUNC_CLEAR: begin
               valid_ff[b]  <= '0;
               spec_ff[b]   <= spec_new;
               miss_ff[b]   <= miss_new;
               missed_ff[b] <= 1'b0;
               fpc_ff[b]    <= '0;
            end
            FUNC_INIT: begin
               param_ff[b] <= cmd.param_index;
               spec_ff[b]  <= cmd.spec_count;
               miss_ff[b]  <= cmd.miss_count;
               mlow_ff[b]  <= cmd.mask_low;
               mhigh_ff[b] <= cmd.mask_high;
               fpc_ff[b]   <= '0;
            end
            default: begin
               if (hit) begin
                  missed_ff[b] <= 1'b1;
               end
            end
         endcase
      end
   end

   // shift the hash history of the selected bank on save
   always_ff @(posedge clock) begin
      if (pop && (cmd.func == FUNC_SAVE)) begin
         for (int i = 1; i < BANK_DEPTH; i++) begin
            hist_ff[b][i] <= hist_ff[b][i-1];
         end
         hist_ff[b][0] <= hash;
      end
   end

   // hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load response payload; unused fields read as zero
   always_ff @(posedge clock) begin
      if (pop) begin
         rollback_ff    <= is_check && hit;
         mlow_out_ff    <= (is_check && hit) ? mlow_ff[b]  : '0;
         mhigh_out_ff   <= (is_check && hit) ? mhigh_ff[b] : '0;
         pc_out_ff      <= (is_check && hit) ? fpc_ff[b]   : '0;
         stats_write_ff <= is_clear;
         stats_index_ff <= is_clear ? {param_ff[b], STATS_SCALE_W'(0)} : '0;
         spec_out_ff    <= is_clear ? spec_new : '0;
         miss_out_ff    <= is_clear ? miss_new : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rollback           = rollback_ff;
   assign rollback_mask_low  = mlow_out_ff;
   assign rollback_mask_high = mhigh_out_ff;
   assign rollback_pc        = pc_out_ff;
   assign stats_write        = stats_write_ff;
   assign stats_index        = stats_index_ff;
   assign stats_spec_count   = spec_out_ff;
   assign stats_miss_count   = miss_out_ff;

   // a response is never both a rollback and a write-back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rollback_ff && stats_write_ff))
      else $error("rollback and write-back in one response");

   // without rollback the rollback payload is zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rollback_ff) |->
         (mlow_out_ff == '0 && mhigh_out_ff == '0 && pc_out_ff == '0))
      else $error("rollback payload not cleared");

   // a clear leaves the bank with no valid entry
   assert property (@(posedge clock) disable iff (reset)
      (pop && is_clear) |=> (valid_ff[$past(b)] == '0))
      else $error("bank still holds valid entries after clear");

endmodule

`default_nettype wire

FILE: rtl/partitioned_load_queue_conflict_check_core.sv
// ----------------------------------------------------------------------------
// partitioned_load_queue_conflict_check_core: four-bank speculative load queue
// Saves hashed load addresses per bank, checks addresses for conflicts,
// clears banks with counter write-back and initializes bank parameters.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the req_ stream (func and bank in tuser, the operands in
//   tdata); each request yields exactly one response on the rsp_ stream, in
//   request order. A check returns rollback with the bank mask and first pc
//   on a hit, a clear returns the updated counters and their table index.
// Path: an accepted request is loaded into the intake register, written into
//   the request queue and executed as the response register loads; a stall
//   can hold it in the queue or leave the response held in its register.
// Throughput: one request per cycle sustained while rsp_tready stays high; the
//   back end executes one request per cycle against the combinational compare.
// Reset: synchronous; empties the intake, queue and response register and
//   clears the valid bits, counters, masks, parameter slots and first pc of
//   all banks. The hash history itself is not cleared.
// Stall: a held response keeps the back end waiting; the queue then absorbs
//   up to four requests plus one in the intake register before req_tready
//   drops.
// ----------------------------------------------------------------------------
`default_nettype none

module partitioned_load_queue_conflict_check_core
   import plq_pkg::*;
#(
   parameter int BANK_DEPTH = 8,
   parameter int HASH_BITS  = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request stream
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // tuser: func [1:0], bank_select [3:2]
   input  wire logic [3:0]    req_tuser,
   // tdata: load_pc [63:0], mem_address [127:64], param_index [135:128],
   //        init_spec_count [151:136], init_miss_count [167:152],
   //        init_mask_low [231:168], init_mask_high [295:232]
   input  wire logic [295:0]  req_tdata,
   // response stream
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // tuser: rollback [0], stats_write [1]
   output logic [1:0]         rsp_tuser,
   // tdata: rollback_mask_low [63:0], rollback_mask_high [127:64],
   //        rollback_pc [191:128], stats_index [202:192],
   //        stats_spec_count [218:203], stats_miss_count [234:219], zero [239:235]
   output logic [239:0]       rsp_tdata
);

   localparam int Q_W = CMD_W + HASH_BITS;

   logic                  push, queue_full, queue_not_empty, pop;
   cmd_type               front_cmd, exec_cmd;
   logic [HASH_BITS-1:0]  front_hash, exec_hash;
   logic [Q_W-1:0]        q_out;

   logic                       rollback, stats_write;
   logic [WORD_W-1:0]          mask_low, mask_high, rb_pc;
   logic [STATS_INDEX_W-1:0]   stats_index;
   logic [COUNT_W-1:0]         spec_count, miss_count;

   // classify incoming requests
   plq_front #(
      .HASH_BITS (HASH_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_func        (req_tuser[1:0]),
      .in_bank        (req_tuser[3:2]),
      .in_load_pc     (req_tdata[63:0]),
      .in_mem_address (req_tdata[127:64]),
      .in_param_index (req_tdata[135:128]),
      .in_spec_count  (req_tdata[151:136]),
      .in_miss_count  (req_tdata[167:152]),
      .in_mask_low    (req_tdata[231:168]),
      .in_mask_high   (req_tdata[295:232]),
      .push           (push),
      .queue_full     (queue_full),
      .cmd            (front_cmd),
      .hash           (front_hash)
   );

   // decouple intake from execution
   plq_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({front_hash, front_cmd}),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_data  (q_out)
   );

   assign exec_cmd  = cmd_type'(q_out[CMD_W-1:0]);
   assign exec_hash = q_out[Q_W-1:CMD_W];

   // execute against bank state
   plq_exec #(
      .BANK_DEPTH (BANK_DEPTH),
      .HASH_BITS  (HASH_BITS)
   ) u_exec (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (queue_not_empty),
      .pop                (pop),
      .cmd                (exec_cmd),
      .hash               (exec_hash),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rollback           (rollback),
      .rollback_mask_low  (mask_low),
      .rollback_mask_high (mask_high),
      .rollback_pc        (rb_pc),
      .stats_write        (stats_write),
      .stats_index        (stats_index),
      .stats_spec_count   (spec_count),
      .stats_miss_count   (miss_count)
   );

   // pack the response
   assign rsp_tuser = {stats_write, rollback};
   assign rsp_tdata = {5'b0, miss_count, spec_count, stats_index, rb_pc, mask_high, mask_low};

endmodule

`default_nettype wire

FILE: sim/tb_partitioned_load_queue_conflict_check_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_partitioned_load_queue_conflict_check_core: conflict check core bench
// Drives save, check, clear and init requests into the four load queue banks.
// The bench keeps its own copy of every bank's history, counters, mask and
// first pc. From that copy it works out the response to each accepted request
// and compares it with the response stream, in order and field by field.
// Both streams idle at random. The response side holds off twice for a long
// stretch so that the request queue fills and back-pressures the sender.
// ----------------------------------------------------------------------------

module tb_partitioned_load_queue_conflict_check_core;
   import plq_pkg::*;

   localparam int CLK_PERIOD   = 4;
   localparam int BANK_DEPTH   = 8;
   localparam int HASH_BITS    = 16;
   localparam int RANDOM_ITEMS = 1850;
   localparam int HOLD_CYCLES  = 250;

   // request payload, last field in the lowest bits of tdata
   typedef struct packed {
      logic [WORD_W-1:0]  mask_high;
      logic [WORD_W-1:0]  mask_low;
      logic [COUNT_W-1:0] miss_count;
      logic [COUNT_W-1:0] spec_count;
      logic [PARAM_W-1:0] param_index;
      logic [WORD_W-1:0]  mem_address;
      logic [WORD_W-1:0]  load_pc;
   } request_type;

   // one response, all fields unpacked from tuser and tdata
   typedef struct packed {
      logic                     rollback;
      logic                     stats_write;
      logic [WORD_W-1:0]        mask_low;
      logic [WORD_W-1:0]        mask_high;
      logic [WORD_W-1:0]        pc;
      logic [STATS_INDEX_W-1:0] index;
      logic [COUNT_W-1:0]       spec_count;
      logic [COUNT_W-1:0]       miss_count;
   } outcome_type;

   // Mirror of the bank state; predicts each response and checks it
   class load_queue_mirror;
      bit [HASH_BITS-1:0] hash_hist [NUM_BANKS][BANK_DEPTH];
      bit                 entry_valid [NUM_BANKS][BANK_DEPTH];
      bit [COUNT_W-1:0]   spec_cnt [NUM_BANKS];
      bit [COUNT_W-1:0]   miss_cnt [NUM_BANKS];
      bit [PARAM_W-1:0]   slot [NUM_BANKS];
      bit [WORD_W-1:0]    mask_lo [NUM_BANKS];
      bit [WORD_W-1:0]    mask_hi [NUM_BANKS];
      bit [WORD_W-1:0]    first_pc [NUM_BANKS];
      bit                 missed [NUM_BANKS];
      outcome_type        expected_outcomes [$];
      int                 errors;
      int                 checked;

      // Apply an accepted request to the mirror and queue its response
      function void note_request(func_type op, logic [BANK_W-1:0] b, request_type rq);
         outcome_type        o;
         bit [HASH_BITS-1:0] h;
         bit                 hit;
         int                 i;
         o   = '0;
         h   = rq.mem_address[HASH_BITS+1:2];
         hit = 1'b0;
         case (op)
            FUNC_SAVE: begin
               // shift toward older slots, newest lands at index 0
               for (i = BANK_DEPTH - 1; i > 0; i--) begin
                  hash_hist[b][i]   = hash_hist[b][i-1];
                  entry_valid[b][i] = entry_valid[b][i-1];
               end
               hash_hist[b][0]   = h;
               entry_valid[b][0] = 1'b1;
               if (first_pc[b] == '0) begin
                  first_pc[b] = rq.load_pc;
               end
            end
            FUNC_CLEAR: begin
               for (i = 0; i < BANK_DEPTH; i++) begin
                  entry_valid[b][i] = 1'b0;
               end
               spec_cnt[b] = spec_cnt[b] + 1'b1;
               if (missed[b]) begin
                  miss_cnt[b] = miss_cnt[b] + 1'b1;
               end
               missed[b] = 1'b0;
               // scale both counters down once the speculation count saturates
               if (spec_cnt[b][COUNT_W-1]) begin
                  spec_cnt[b] = spec_cnt[b] >> COUNT_SHIFT;
                  miss_cnt[b] = miss_cnt[b] >> COUNT_SHIFT;
               end
               first_pc[b]   = '0;
               o.stats_write = 1'b1;
               o.index       = STATS_INDEX_W'(slot[b]) << STATS_SCALE_W;
               o.spec_count  = spec_cnt[b];
               o.miss_count  = miss_cnt[b];
            end
            FUNC_INIT: begin
               slot[b]     = rq.param_index;
               spec_cnt[b] = rq.spec_count;
               miss_cnt[b] = rq.miss_count;
               mask_lo[b]  = rq.mask_low;
               mask_hi[b]  = rq.mask_high;
               first_pc[b] = '0;
            end
            default: begin
               // compare against valid entries only
               for (i = 0; i < BANK_DEPTH; i++) begin
                  if (entry_valid[b][i] && hash_hist[b][i] == h) begin
                     hit = 1'b1;
                  end
               end
               if (hit) begin
                  missed[b]   = 1'b1;
                  o.rollback  = 1'b1;
                  o.mask_low  = mask_lo[b];
                  o.mask_high = mask_hi[b];
                  o.pc        = first_pc[b];
               end
            end
         endcase
         expected_outcomes.push_back(o);
      endfunction

      // Compare one accepted response with the oldest expected one
      function void check_response(logic [1:0] user, logic [239:0] data);
         outcome_type got;
         outcome_type want;
         got.rollback    = user[0];
         got.stats_write = user[1];
         got.mask_low    = data[63:0];
         got.mask_high   = data[127:64];
         got.pc          = data[191:128];
         got.index       = data[202:192];
         got.spec_count  = data[218:203];
         got.miss_count  = data[234:219];
         checked++;
         if (expected_outcomes.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("response %0d arrived with none pending: rb=%b sw=%b",
                        checked, got.rollback, got.stats_write);
            end
            return;
         end
         want = expected_outcomes.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("response %0d mismatch", checked);
               $display("  expected rb=%b mask=%h_%h pc=%h sw=%b idx=%0d spec=%h miss=%h",
                        want.rollback, want.mask_high, want.mask_low, want.pc,
                        want.stats_write, want.index, want.spec_count, want.miss_count);
               $display("  actual   rb=%b mask=%h_%h pc=%h sw=%b idx=%0d spec=%h miss=%h",
                        got.rollback, got.mask_high, got.mask_low, got.pc,
                        got.stats_write, got.index, got.spec_count, got.miss_count);
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [3:0]           req_tuser = '0;
   logic [295:0]         req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [1:0]           rsp_tuser;
   logic [239:0]         rsp_tdata;

   load_queue_mirror     mirror = new();
   int                   issued = 0;
   int                   rsp_count = 0;
   bit                   req_idle_on = 1'b1;

   always #(CLK_PERIOD / 2) clock = ~clock;

   partitioned_load_queue_conflict_check_core #(
      .BANK_DEPTH (BANK_DEPTH),
      .HASH_BITS  (HASH_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // Fill every payload field with random bits
   function automatic request_type random_request();
      request_type rq;
      rq.load_pc     = {$urandom, $urandom};
      rq.mem_address = {$urandom, $urandom};
      rq.param_index = PARAM_W'($urandom);
      rq.spec_count  = COUNT_W'($urandom);
      rq.miss_count  = COUNT_W'($urandom);
      rq.mask_low    = {$urandom, $urandom};
      rq.mask_high   = {$urandom, $urandom};
      return rq;
   endfunction

   // Offer one request after a random gap and hold it until accepted
   task automatic push_request(input func_type op, input logic [BANK_W-1:0] b,
                               input request_type rq);
      int gap;
      if (issued % 50 == 0) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
      end
      gap = req_idle_on ? $urandom_range(0, 6) : 0;
      repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= {b, op};
      req_tdata  <= rq;
      do @(posedge clock); while (!req_tready);
      mirror.note_request(op, b, rq);
      issued++;
   endtask

   // Response side: random stalls, two long hold-offs, check every response
   initial begin : response_sink
      int gap;
      bit idle_on;
      idle_on = 1'b1;
      wait (!reset);
      forever begin
         if (rsp_count % 50 == 0) begin
            idle_on = ($urandom_range(0, 3) != 0);
         end
         gap = idle_on ? $urandom_range(0, 6) : 0;
         if (rsp_count == 400 || rsp_count == 1300) begin
            gap = HOLD_CYCLES;
         end
         repeat (gap) @(negedge clock) rsp_tready <= 1'b0;
         @(negedge clock) rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         mirror.check_response(rsp_tuser, rsp_tdata);
         rsp_count++;
      end
   end

   // Stimulus: directed corner cases, then random bank episodes
   initial begin : stimulus
      request_type        rq;
      func_type           op;
      logic [BANK_W-1:0]  b;
      bit [HASH_BITS-1:0] pool [4];
      int                 sent;
      int                 n;
      int                 r;
      int                 j;

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // check an empty bank: no hit
      rq = random_request();
      push_request(FUNC_CHECK, 2'd0, rq);

      // init bank 0 with extreme parameter, counters and mask
      rq = random_request();
      rq.param_index = '1;
      rq.spec_count  = 16'h7FFF;
      rq.miss_count  = 16'hFFFF;
      rq.mask_low    = '1;
      rq.mask_high   = 64'hAAAA_5555_AAAA_5555;
      push_request(FUNC_INIT, 2'd0, rq);

      // save with zero pc leaves first pc unset, next save records its pc
      rq = random_request();
      rq.load_pc     = '0;
      rq.mem_address = '1;
      push_request(FUNC_SAVE, 2'd0, rq);
      rq = random_request();
      rq.load_pc     = '1;
      rq.mem_address = '0;
      push_request(FUNC_SAVE, 2'd0, rq);

      // hit on exact address, hit on an alias with the same hash, then a miss
      rq = random_request();
      rq.mem_address = '1;
      push_request(FUNC_CHECK, 2'd0, rq);
      rq = random_request();
      rq.mem_address = 64'h0000_0000_0003_FFFC;
      push_request(FUNC_CHECK, 2'd0, rq);
      rq = random_request();
      rq.mem_address = 64'h4;
      push_request(FUNC_CHECK, 2'd0, rq);

      // clear: miss counter wraps, speculation counter saturates and scales
      rq = random_request();
      push_request(FUNC_CLEAR, 2'd0, rq);
      rq = random_request();
      rq.mem_address = '1;
      push_request(FUNC_CHECK, 2'd0, rq);

      // speculation counter wraps to zero without scaling
      rq = random_request();
      rq.param_index = '0;
      rq.spec_count  = 16'hFFFF;
      push_request(FUNC_INIT, 2'd1, rq);
      rq = random_request();
      push_request(FUNC_CLEAR, 2'd1, rq);

      // overfill bank 1 so the oldest entry drops out
      for (j = 0; j <= BANK_DEPTH; j++) begin
         rq = random_request();
         rq.mem_address[HASH_BITS+1:2] = HASH_BITS'(j + 1);
         push_request(FUNC_SAVE, 2'd1, rq);
      end
      rq = random_request();
      rq.mem_address[HASH_BITS+1:2] = HASH_BITS'(1);
      push_request(FUNC_CHECK, 2'd1, rq);
      rq = random_request();
      rq.mem_address[HASH_BITS+1:2] = HASH_BITS'(2);
      push_request(FUNC_CHECK, 2'd1, rq);

      // untouched banks: check, clear from reset state, all-zero init
      rq = random_request();
      push_request(FUNC_CHECK, 2'd2, rq);
      rq = random_request();
      push_request(FUNC_CLEAR, 2'd2, rq);
      rq = '0;
      push_request(FUNC_INIT, 2'd3, rq);

      // random part: mostly save/check episodes on one bank, some noise
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            rq = random_request();
            op = func_type'($urandom_range(0, 3));
            b  = BANK_W'($urandom_range(0, NUM_BANKS - 1));
            push_request(op, b, rq);
            sent++;
         end else begin
            b = BANK_W'($urandom_range(0, NUM_BANKS - 1));
            for (j = 0; j < 4; j++) begin
               pool[j] = HASH_BITS'($urandom);
            end
            n = $urandom_range(2, 14);
            repeat (n) begin
               rq = random_request();
               r  = $urandom_range(0, 19);
               if (r == 0) begin
                  op = FUNC_INIT;
                  // bias counters toward saturation and wrap
                  case ($urandom_range(0, 2))
                     0: rq.spec_count = COUNT_W'($urandom_range(16'h7FF0, 16'h7FFF));
                     1: rq.spec_count = COUNT_W'($urandom_range(16'hFFF8, 16'hFFFF));
                     default: ;
                  endcase
               end else if (r <= 2) begin
                  op = FUNC_CLEAR;
               end else if (r <= 10) begin
                  op = FUNC_SAVE;
                  if ($urandom_range(0, 7) == 0) begin
                     rq.load_pc = '0;
                  end
                  rq.mem_address[HASH_BITS+1:2] = pool[$urandom_range(0, 3)];
               end else begin
                  op = FUNC_CHECK;
                  if ($urandom_range(0, 4) != 0) begin
                     rq.mem_address[HASH_BITS+1:2] = pool[$urandom_range(0, 3)];
                  end
               end
               push_request(op, b, rq);
               sent++;
            end
         end
      end

      // drain: wait for every pending response, then report success or failure
      @(negedge clock) req_tvalid <= 1'b0;
      while (mirror.expected_outcomes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (mirror.errors == 0 && mirror.expected_outcomes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog for a hung handshake
   initial begin : watchdog
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
